// ===== design/smld_pkg.sv =====
// Shared types and constants for the shaded midpoint line drawer.
`default_nettype none

package smld_pkg;

  // Number of color channels (red, green, blue)
  localparam int NUM_CHAN = 3;
  // Width of one color intensity
  localparam int COLOR_BITS = 8;

  // Input operation codes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_ISSUE,
    ST_DIV_WAIT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_line;
    logic       advance;
    logic       div_start;
    logic       step_wr;
    logic [1:0] chan;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic active;
    logic span_zero;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/smld_in_if.sv =====
// Input channel of the line drawer: start and advance beats.
`default_nettype none

interface smld_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic [0:0]                   operation;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [7:0]                   red_start;
  logic [7:0]                   green_start;
  logic [7:0]                   blue_start;
  logic [7:0]                   red_end;
  logic [7:0]                   green_end;
  logic [7:0]                   blue_end;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end,
           red_start, green_start, blue_start, red_end, green_end, blue_end,
    input  ready
  );

  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end,
           red_start, green_start, blue_start, red_end, green_end, blue_end,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/smld_out_if.sv =====
// Output channel of the line drawer: one shaded pixel per beat.
`default_nettype none

interface smld_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [7:0]                   red_out;
  logic [7:0]                   green_out;
  logic [7:0]                   blue_out;
  logic                         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, red_out, green_out, blue_out, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/shaded_midpoint_line_drawer.sv =====
// Shaded midpoint line drawer: top level joining controller and datapath.
//
// Channels: line_in carries start beats (operation 0: two endpoints and two
// RGB colors) and advance beats (operation 1). pixel_out carries one shaded
// pixel per advance beat with coordinates, rounded 8-bit colors and a flag
// on the last pixel of the line.
// A start beat yields no pixel. After it, line_in stays low on ready while
// one shared radix-2 divider works out the three color steps in turn, one
// quotient bit per cycle; no division is run when the endpoints share the
// major coordinate (no pixels).
// An advance beat's pixel shows on pixel_out in the cycle after the beat is
// taken. Advance beats are taken every cycle while the output register is
// empty or being drained, so a line streams at one pixel per cycle.
// An advance beat with no line in progress is dropped without a pixel.
// When the receiver stalls, the pixel is held and line_in ready drops.
// A start beat during a line drops the rest of it.
// Reset (rst, synchronous) empties the output and leaves the block idle.
`default_nettype none

module shaded_midpoint_line_drawer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  smld_in_if.sink   line_in,
  smld_out_if.source pixel_out
);

  smld_pkg::dp_cmd_t    cmd;
  smld_pkg::dp_status_t status;

  smld_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (line_in.valid),
    .in_operation (line_in.operation),
    .in_ready     (line_in.ready),
    .out_valid    (pixel_out.valid),
    .out_ready    (pixel_out.ready),
    .status       (status),
    .cmd          (cmd)
  );

  smld_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .x_start     (line_in.x_start),
    .y_start     (line_in.y_start),
    .x_end       (line_in.x_end),
    .y_end       (line_in.y_end),
    .red_start   (line_in.red_start),
    .green_start (line_in.green_start),
    .blue_start  (line_in.blue_start),
    .red_end     (line_in.red_end),
    .green_end   (line_in.green_end),
    .blue_end    (line_in.blue_end),
    .pixel_x     (pixel_out.pixel_x),
    .pixel_y     (pixel_out.pixel_y),
    .red_out     (pixel_out.red_out),
    .green_out   (pixel_out.green_out),
    .blue_out    (pixel_out.blue_out),
    .last_pixel  (pixel_out.last_pixel)
  );

endmodule

`default_nettype wire

// ===== design/smld_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module smld_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             qbit;

  // Shift in next dividend bit and try a subtract
  always_comb begin
    trial     = {rem, quotient[NUM_W-1]};
    trial_sub = trial - {1'b0, divisor_q};
    qbit      = (trial >= {1'b0, divisor_q});
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= '0;
      quotient  <= dividend;
      divisor_q <= divisor;
    end else if (busy) begin
      rem      <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

// ===== design/smld_dp.sv =====
// Datapath: line setup, midpoint walk, color interpolation and pixel register.
`default_nettype none

module smld_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire smld_pkg::dp_cmd_t            cmd,
  output smld_pkg::dp_status_t              status,
  input  wire logic signed [COORD_BITS-1:0] x_start,
  input  wire logic signed [COORD_BITS-1:0] y_start,
  input  wire logic signed [COORD_BITS-1:0] x_end,
  input  wire logic signed [COORD_BITS-1:0] y_end,
  input  wire logic [7:0]                   red_start,
  input  wire logic [7:0]                   green_start,
  input  wire logic [7:0]                   blue_start,
  input  wire logic [7:0]                   red_end,
  input  wire logic [7:0]                   green_end,
  input  wire logic [7:0]                   blue_end,
  output logic signed [COORD_BITS-1:0]      pixel_x,
  output logic signed [COORD_BITS-1:0]      pixel_y,
  output logic [7:0]                        red_out,
  output logic [7:0]                        green_out,
  output logic [7:0]                        blue_out,
  output logic                              last_pixel
);

  localparam int C     = COORD_BITS;
  localparam int CB    = smld_pkg::COLOR_BITS;
  localparam int NCH   = smld_pkg::NUM_CHAN;
  localparam int ERR_W = C + 3;
  localparam int NUM_W = FRAC_BITS + CB + 1;
  localparam int ACC_W = FRAC_BITS + CB + 2;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Line state
  logic                     active;
  logic                     steep;
  logic signed [C-1:0]      major_pos;
  logic signed [C-1:0]      major_end;
  logic signed [C-1:0]      minor_pos;
  logic                     minor_down;
  logic signed [ERR_W-1:0]  error_term;
  logic [C-1:0]             major_span;
  logic [C-1:0]             minor_span;
  acc_t                     color_accum [NCH];
  acc_t                     color_step  [NCH];
  logic signed [CB:0]       color_diff  [NCH];

  // Setup logic
  logic signed [C:0]        dx, dy, ddiff_a, ddiff_b;
  logic [C:0]               adx, ady, abs_b;
  logic                     steep_in, swap_in;
  logic signed [C-1:0]      a0, a1, b0, b1, p0, p1, q0, q1;
  logic [CB-1:0]            cs [NCH];
  logic [CB-1:0]            ce [NCH];
  logic [CB-1:0]            c0 [NCH];
  logic [CB-1:0]            c1 [NCH];

  // Walk logic
  logic signed [ERR_W-1:0]  err_sub;
  logic                     last;
  logic [CB-1:0]            color_px [NCH];
  logic signed [ACC_W:0]    rounded;
  logic signed [ACC_W:0]    shifted;

  // Divider hookup
  logic signed [CB:0]       sel_diff;
  logic [CB-1:0]            sel_mag;
  logic [NUM_W-1:0]         dividend;
  logic                     div_done;
  logic [NUM_W-1:0]         quotient;
  acc_t                     step_val;

  // Swap axes when steep, then order endpoints along the major axis
  always_comb begin
    cs[0] = red_start; cs[1] = green_start; cs[2] = blue_start;
    ce[0] = red_end;   ce[1] = green_end;   ce[2] = blue_end;
    dx  = {x_end[C-1], x_end} - {x_start[C-1], x_start};
    dy  = {y_end[C-1], y_end} - {y_start[C-1], y_start};
    adx = dx[C] ? -dx : dx;
    ady = dy[C] ? -dy : dy;
    steep_in = ady > adx;
    p0 = steep_in ? y_start : x_start;
    q0 = steep_in ? x_start : y_start;
    p1 = steep_in ? y_end   : x_end;
    q1 = steep_in ? x_end   : y_end;
    swap_in = p0 > p1;
    a0 = swap_in ? p1 : p0;
    a1 = swap_in ? p0 : p1;
    b0 = swap_in ? q1 : q0;
    b1 = swap_in ? q0 : q1;
    for (int i = 0; i < NCH; i++) begin
      c0[i] = swap_in ? ce[i] : cs[i];
      c1[i] = swap_in ? cs[i] : ce[i];
    end
    ddiff_a = {a1[C-1], a1} - {a0[C-1], a0};
    ddiff_b = {b1[C-1], b1} - {b0[C-1], b0};
    abs_b   = ddiff_b[C] ? -ddiff_b : ddiff_b;
  end

  // Midpoint step and pixel colors
  always_comb begin
    err_sub = error_term - {2'b00, minor_span, 1'b0};
    last    = major_pos >= major_end;
    rounded = '0;
    shifted = '0;
    for (int i = 0; i < NCH; i++) begin
      rounded = {color_accum[i][ACC_W-1], color_accum[i]}
              + (ACC_W+1)'(1 << (FRAC_BITS - 1));
      shifted = rounded >>> FRAC_BITS;
      if (rounded < 0) begin
        color_px[i] = '0;
      end else if (shifted > (ACC_W+1)'(255)) begin
        color_px[i] = '1;
      end else begin
        color_px[i] = shifted[CB-1:0];
      end
    end
  end

  // Rounded dividend for the selected channel: |diff| * 2^F + span / 2
  always_comb begin
    sel_diff = color_diff[cmd.chan];
    sel_mag  = sel_diff[CB] ? CB'(-sel_diff) : sel_diff[CB-1:0];
    dividend = NUM_W'({sel_mag, {FRAC_BITS{1'b0}}}) + NUM_W'(major_span >> 1);
    step_val = sel_diff[CB] ? -ACC_W'(quotient) : ACC_W'(quotient);
  end

  smld_div #(
    .NUM_W (NUM_W),
    .DEN_W (C)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (major_span),
    .done     (div_done),
    .quotient (quotient)
  );

  // Active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.load_line) begin
      active <= ddiff_a != '0;
    end else if (cmd.advance && last) begin
      active <= 1'b0;
    end
  end

  // Load a new line or advance one pixel
  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      steep      <= steep_in;
      major_pos  <= a0;
      major_end  <= a1;
      minor_pos  <= b0;
      minor_down <= b0 >= b1;
      major_span <= ddiff_a[C-1:0];
      minor_span <= abs_b[C-1:0];
      error_term <= ERR_W'(ddiff_a[C-1:0]);
      for (int i = 0; i < NCH; i++) begin
        color_accum[i] <= ACC_W'({c0[i], {FRAC_BITS{1'b0}}});
        color_step[i]  <= '0;
        color_diff[i]  <= {1'b0, c1[i]} - {1'b0, c0[i]};
      end
    end else begin
      if (cmd.step_wr) begin
        color_step[cmd.chan] <= step_val;
      end
      if (cmd.advance) begin
        pixel_x    <= steep ? minor_pos : major_pos;
        pixel_y    <= steep ? major_pos : minor_pos;
        red_out    <= color_px[0];
        green_out  <= color_px[1];
        blue_out   <= color_px[2];
        last_pixel <= last;
        if (err_sub < 0) begin
          minor_pos  <= minor_down ? minor_pos - C'(1) : minor_pos + C'(1);
          error_term <= err_sub + {2'b00, major_span, 1'b0};
        end else begin
          error_term <= err_sub;
        end
        major_pos <= major_pos + C'(1);
        for (int i = 0; i < NCH; i++) begin
          color_accum[i] <= color_accum[i] + color_step[i];
        end
      end
    end
  end

  assign status.active    = active;
  assign status.span_zero = major_span == '0;
  assign status.div_done  = div_done;

endmodule

`default_nettype wire

// ===== design/smld_ctrl.sv =====
// Controller: handshakes, output valid and color-step division sequence.
`default_nettype none

module smld_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [0:0]           in_operation,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire smld_pkg::dp_status_t status,
  output smld_pkg::dp_cmd_t         cmd
);

  localparam logic [1:0] LAST_CHAN = 2'(smld_pkg::NUM_CHAN - 1);

  smld_pkg::ctrl_state_t state, state_next;
  logic [1:0]            chan, chan_next;
  logic                  out_valid_next;
  logic                  in_fire;

  // State, channel counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smld_pkg::ST_IDLE;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chan      <= chan_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    chan_next     = chan;
    cmd.div_start = 1'b0;
    cmd.step_wr   = 1'b0;
    cmd.chan      = chan;

    in_ready = (state == smld_pkg::ST_IDLE) && (!out_valid || out_ready);
    in_fire  = in_valid && in_ready;
    cmd.load_line = in_fire && (in_operation == smld_pkg::OP_START);
    cmd.advance   = in_fire && (in_operation == smld_pkg::OP_ADVANCE) && status.active;

    // Hold the pixel until taken; refill on advance
    if (cmd.advance) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    unique case (state)
      smld_pkg::ST_IDLE: begin
        if (cmd.load_line) begin
          state_next = smld_pkg::ST_DIV_ISSUE;
          chan_next  = '0;
        end
      end
      smld_pkg::ST_DIV_ISSUE: begin
        if (status.span_zero) begin
          state_next = smld_pkg::ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = smld_pkg::ST_DIV_WAIT;
        end
      end
      smld_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.step_wr = 1'b1;
          if (chan == LAST_CHAN) begin
            state_next = smld_pkg::ST_IDLE;
          end else begin
            chan_next  = chan + 2'd1;
            state_next = smld_pkg::ST_DIV_ISSUE;
          end
        end
      end
      default: begin
        state_next = smld_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the shaded midpoint line drawer: random and directed line walks.
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 16;
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1720;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int COORD_MIN    = -2048;
  localparam int COORD_MAX    = 2047;

  typedef struct packed {
    smld_pkg::op_t                operation;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [7:0]                   red_start;
    logic [7:0]                   green_start;
    logic [7:0]                   blue_start;
    logic [7:0]                   red_end;
    logic [7:0]                   green_end;
    logic [7:0]                   blue_end;
  } line_beat_t;

  typedef struct packed {
    line_beat_t beat;
    logic [3:0] gap;
    logic       wait_drain;
    logic       stall_sink;
  } line_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [7:0]                   red_out;
    logic [7:0]                   green_out;
    logic [7:0]                   blue_out;
    logic                         last_pixel;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smld_in_if  #(.COORD_BITS(COORD_BITS)) line_ch ();
  smld_out_if #(.COORD_BITS(COORD_BITS)) pixel_ch ();

  shaded_midpoint_line_drawer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .line_in  (line_ch),
    .pixel_out(pixel_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  line_item_t pending_beats[$];
  pixel_t     expected_pixels[$];
  int         error_count = 0;
  bit         tx_burst = 1'b0;
  bit         sink_hold_req = 1'b0;

  // Line walk state of the predictor
  bit                           walk_active = 1'b0;
  bit                           walk_steep = 1'b0;
  bit                           walk_minor_down = 1'b0;
  logic signed [COORD_BITS-1:0] major_pos = '0;
  logic signed [COORD_BITS-1:0] major_end = '0;
  logic signed [COORD_BITS-1:0] minor_pos = '0;
  logic signed [14:0]           err_term = '0;
  logic [12:0]                  major_span = '0;
  logic [12:0]                  minor_span = '0;
  logic signed [25:0]           shade_accum [smld_pkg::NUM_CHAN];
  logic signed [25:0]           shade_step [smld_pkg::NUM_CHAN];

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Round a fixed-point accumulator to an 8-bit intensity, clamped
  function automatic logic [7:0] shade_level(input logic signed [25:0] acc);
    int v;
    v = int'(acc) + (1 << (FRAC_BITS - 1));
    if (v < 0) return 8'd0;
    v = v >>> FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Apply one accepted beat to the line walk and queue the pixel it yields
  task automatic trace_line_beat(input line_beat_t b);
    int a0, b0, a1, b1, t, span, diff, q, err;
    int c0 [smld_pkg::NUM_CHAN];
    int c1 [smld_pkg::NUM_CHAN];
    pixel_t pix;
    if (b.operation == smld_pkg::OP_START) begin
      a0 = int'($signed(b.x_start));
      b0 = int'($signed(b.y_start));
      a1 = int'($signed(b.x_end));
      b1 = int'($signed(b.y_end));
      c0[0] = int'(b.red_start);
      c0[1] = int'(b.green_start);
      c0[2] = int'(b.blue_start);
      c1[0] = int'(b.red_end);
      c1[1] = int'(b.green_end);
      c1[2] = int'(b.blue_end);
      walk_steep = magnitude(b1 - b0) > magnitude(a1 - a0);
      if (walk_steep) begin
        t = a0; a0 = b0; b0 = t;
        t = a1; a1 = b1; b1 = t;
      end
      // order endpoints so the major axis counts up, colors follow
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
        for (int i = 0; i < smld_pkg::NUM_CHAN; i++) begin
          t = c0[i]; c0[i] = c1[i]; c1[i] = t;
        end
      end
      span = a1 - a0;
      major_pos = a0[COORD_BITS-1:0];
      major_end = a1[COORD_BITS-1:0];
      minor_pos = b0[COORD_BITS-1:0];
      walk_minor_down = (b0 >= b1);
      major_span = span[12:0];
      minor_span = 13'(magnitude(b1 - b0));
      err_term = span[14:0];
      for (int i = 0; i < smld_pkg::NUM_CHAN; i++) begin
        shade_accum[i] = 26'(c0[i] * (1 << FRAC_BITS));
        if (span > 0) begin
          diff = c1[i] - c0[i];
          q = ((magnitude(diff) << FRAC_BITS) + span / 2) / span;
          shade_step[i] = 26'((diff < 0) ? -q : q);
        end else begin
          shade_step[i] = '0;
        end
      end
      walk_active = (span > 0);
    end else if (walk_active) begin
      pix.pixel_x = walk_steep ? minor_pos : major_pos;
      pix.pixel_y = walk_steep ? major_pos : minor_pos;
      pix.red_out = shade_level(shade_accum[0]);
      pix.green_out = shade_level(shade_accum[1]);
      pix.blue_out = shade_level(shade_accum[2]);
      pix.last_pixel = (major_pos >= major_end);
      expected_pixels.push_back(pix);
      // midpoint step on the minor axis
      err = int'(err_term) - 2 * int'(minor_span);
      if (err < 0) begin
        minor_pos = walk_minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        err = err + 2 * int'(major_span);
      end
      err_term = err[14:0];
      major_pos = major_pos + 1'b1;
      for (int i = 0; i < smld_pkg::NUM_CHAN; i++) begin
        shade_accum[i] = shade_accum[i] + shade_step[i];
      end
      if (pix.last_pixel) walk_active = 1'b0;
    end
  endtask

  function automatic line_beat_t start_beat(input int xs, input int ys, input int xe,
                                            input int ye, input logic [23:0] rgb_s,
                                            input logic [23:0] rgb_e);
    line_beat_t b;
    b.operation   = smld_pkg::OP_START;
    b.x_start     = xs[COORD_BITS-1:0];
    b.y_start     = ys[COORD_BITS-1:0];
    b.x_end       = xe[COORD_BITS-1:0];
    b.y_end       = ye[COORD_BITS-1:0];
    b.red_start   = rgb_s[23:16];
    b.green_start = rgb_s[15:8];
    b.blue_start  = rgb_s[7:0];
    b.red_end     = rgb_e[23:16];
    b.green_end   = rgb_e[15:8];
    b.blue_end    = rgb_e[7:0];
    return b;
  endfunction

  // Advance beat; the unused payload carries random bits
  function automatic line_beat_t advance_beat();
    line_beat_t b;
    b = start_beat($urandom, $urandom, $urandom, $urandom, 24'($urandom), 24'($urandom));
    b.operation = smld_pkg::OP_ADVANCE;
    return b;
  endfunction

  task automatic add_beat(input line_beat_t b, input bit wait_drain = 1'b0,
                          input bit stall_sink = 1'b0);
    line_item_t item;
    item.beat = b;
    item.gap = tx_burst ? 4'd0 : 4'($urandom_range(0, 9));
    item.wait_drain = wait_drain;
    item.stall_sink = stall_sink;
    pending_beats.push_back(item);
  endtask

  function automatic logic [23:0] random_rgb();
    unique case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Driver: offer queued beats, honoring gaps and drain pauses
  line_item_t cur_item;
  bit         tx_holding = 1'b0;
  bit         tx_taken;
  int         tx_gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      line_ch.valid <= 1'b0;
      tx_holding = 1'b0;
    end else begin
      tx_taken = line_ch.valid && line_ch.ready;
      if (tx_taken) begin
        trace_line_beat(cur_item.beat);
        tx_holding = 1'b0;
      end
      if (!tx_holding && pending_beats.size() > 0) begin
        cur_item = pending_beats.pop_front();
        tx_gap_left = int'(cur_item.gap);
        tx_holding = 1'b1;
      end
      if (!tx_holding) begin
        line_ch.valid <= 1'b0;
      end else if (!(line_ch.valid && !tx_taken)) begin
        if (cur_item.wait_drain && expected_pixels.size() != 0) begin
          line_ch.valid <= 1'b0;
        end else if (tx_gap_left > 0) begin
          tx_gap_left--;
          line_ch.valid <= 1'b0;
        end else begin
          cur_item.wait_drain = 1'b0;
          if (cur_item.stall_sink) sink_hold_req = 1'b1;
          line_ch.operation   <= cur_item.beat.operation;
          line_ch.x_start     <= cur_item.beat.x_start;
          line_ch.y_start     <= cur_item.beat.y_start;
          line_ch.x_end       <= cur_item.beat.x_end;
          line_ch.y_end       <= cur_item.beat.y_end;
          line_ch.red_start   <= cur_item.beat.red_start;
          line_ch.green_start <= cur_item.beat.green_start;
          line_ch.blue_start  <= cur_item.beat.blue_start;
          line_ch.red_end     <= cur_item.beat.red_end;
          line_ch.green_end   <= cur_item.beat.green_end;
          line_ch.blue_end    <= cur_item.beat.blue_end;
          line_ch.valid       <= 1'b1;
        end
      end
    end
  end

  // Monitor: take pixels with random stalls and compare against the oldest expectation
  pixel_t got_pixel;
  pixel_t want_pixel;
  int     pixels_seen = 0;
  int     rx_wait = 0;
  int     rx_hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.ready <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        got_pixel.pixel_x = pixel_ch.pixel_x;
        got_pixel.pixel_y = pixel_ch.pixel_y;
        got_pixel.red_out = pixel_ch.red_out;
        got_pixel.green_out = pixel_ch.green_out;
        got_pixel.blue_out = pixel_ch.blue_out;
        got_pixel.last_pixel = pixel_ch.last_pixel;
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel at (%0d, %0d)", got_pixel.pixel_x, got_pixel.pixel_y);
          error_count++;
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (got_pixel.pixel_x !== want_pixel.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want_pixel.pixel_x, got_pixel.pixel_x);
            error_count++;
          end
          if (got_pixel.pixel_y !== want_pixel.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want_pixel.pixel_y, got_pixel.pixel_y);
            error_count++;
          end
          if (got_pixel.red_out !== want_pixel.red_out) begin
            $error("red_out: expected %0d, got %0d", want_pixel.red_out, got_pixel.red_out);
            error_count++;
          end
          if (got_pixel.green_out !== want_pixel.green_out) begin
            $error("green_out: expected %0d, got %0d", want_pixel.green_out,
                   got_pixel.green_out);
            error_count++;
          end
          if (got_pixel.blue_out !== want_pixel.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want_pixel.blue_out, got_pixel.blue_out);
            error_count++;
          end
          if (got_pixel.last_pixel !== want_pixel.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want_pixel.last_pixel,
                   got_pixel.last_pixel);
            error_count++;
          end
        end
        pixels_seen++;
        rx_wait = ((pixels_seen / 128) % 3 == 1) ? 0 : $urandom_range(0, 9);
      end
      if (sink_hold_req) begin
        rx_hold_left = LONG_HOLD;
        sink_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pixel_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pixel_ch.ready <= 1'b0;
      end else begin
        pixel_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (line_ch.valid && line_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed lines, a backpressure line, then random line walks
  initial begin
    int line_items, seq, pick, span_max, dx, dy, xs, ys, xe, ye, steps, n_adv;
    bit flat;

    line_ch.valid = 1'b0;
    line_ch.operation = smld_pkg::OP_START;
    line_ch.x_start = '0;
    line_ch.y_start = '0;
    line_ch.x_end = '0;
    line_ch.y_end = '0;
    line_ch.red_start = '0;
    line_ch.green_start = '0;
    line_ch.blue_start = '0;
    line_ch.red_end = '0;
    line_ch.green_end = '0;
    line_ch.blue_end = '0;
    pixel_ch.ready = 1'b0;

    // advance with no line in progress
    add_beat(advance_beat());
    // equal endpoints at the coordinate extremes
    add_beat(start_beat(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 24'hFF00FF, 24'h00FF00));
    add_beat(advance_beat());
    // shallow line at the top corner, one advance past its end
    add_beat(start_beat(2045, 2047, 2047, 2046, 24'hFF00FF, 24'h00FF00));
    repeat (4) add_beat(advance_beat());
    // steep line given in reverse order, colors swap with it
    add_beat(start_beat(-2047, -2044, COORD_MIN, COORD_MIN, 24'h000000, 24'hFFFFFF));
    repeat (5) add_beat(advance_beat());
    // full-width line dropped by the next start
    add_beat(start_beat(COORD_MIN, 0, COORD_MAX, 5, 24'hFFFFFF, 24'h000000));
    repeat (3) add_beat(advance_beat());
    // full-height vertical line, also dropped
    add_beat(start_beat(5, COORD_MAX, 5, COORD_MIN, 24'h00FF80, 24'hFF0001));
    repeat (2) add_beat(advance_beat());
    // diagonal, equal spans, walking down
    add_beat(start_beat(0, 0, 2, -2, 24'h7F8081, 24'h80817F));
    repeat (3) add_beat(advance_beat());

    // long line with the receiver held off while advances keep coming
    tx_burst = 1'b1;
    add_beat(start_beat(-60, 10, 60, -30, random_rgb(), random_rgb()), 1'b1);
    add_beat(advance_beat(), 1'b0, 1'b1);
    repeat (120) add_beat(advance_beat());

    line_items = 0;
    seq = 0;
    while (line_items < RANDOM_ITEMS) begin
      tx_burst = ((seq / 16) % 4 == 3);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // stray advance
        add_beat(advance_beat());
      end else begin
        pick = $urandom_range(0, 99);
        flat = (pick < 3);
        span_max = (pick < 83) ? 24 : (pick < 95) ? 300 : 0;
        if (span_max == 0 && !flat) begin
          xs = int'($urandom_range(0, 4095)) + COORD_MIN;
          ys = int'($urandom_range(0, 4095)) + COORD_MIN;
          xe = int'($urandom_range(0, 4095)) + COORD_MIN;
          ye = int'($urandom_range(0, 4095)) + COORD_MIN;
        end else begin
          dx = flat ? 0 : int'($urandom_range(0, 2 * span_max)) - span_max;
          dy = flat ? 0 : int'($urandom_range(0, 2 * span_max)) - span_max;
          xs = int'($urandom_range(0, 4095)) + COORD_MIN;
          ys = int'($urandom_range(0, 4095)) + COORD_MIN;
          xe = xs + dx;
          if (xe > COORD_MAX || xe < COORD_MIN) xe = xs - dx;
          ye = ys + dy;
          if (ye > COORD_MAX || ye < COORD_MIN) ye = ys - dy;
        end
        steps = (xs == xe && ys == ye) ? 0 :
                ((magnitude(xe - xs) > magnitude(ye - ys)) ? magnitude(xe - xs)
                                                             : magnitude(ye - ys)) + 1;
        add_beat(start_beat(xs, ys, xe, ye, random_rgb(), random_rgb()),
                 $urandom_range(0, 24) == 0);
        line_items++;
        // mostly whole lines; some overrun the end, some are cut short
        pick = $urandom_range(0, 9);
        n_adv = steps;
        if (pick == 0) n_adv = steps + int'($urandom_range(1, 3));
        else if (pick == 1 && steps > 0) n_adv = $urandom_range(0, steps - 1);
        if (steps > 601) n_adv = $urandom_range(1, 64);
        repeat (n_adv) add_beat(advance_beat());
        line_items += (n_adv < steps) ? n_adv : steps;
      end
      seq++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || tx_holding || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_pixels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
